>>> hdl/refcounted_slot_table_assert.svh
// assertion macros used by the slot table datapath
`ifndef REFCOUNTED_SLOT_TABLE_ASSERT_SVH
`define REFCOUNTED_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RCST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot table check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define RCST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot table check failed");

`endif

>>> hdl/rcst_pkg.sv
// shared types, codes and constants of the slot table
package rcst_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_W       = 7;
    localparam int REQ_W       = 2;
    localparam int ID_W        = 8;
    localparam int STATUS_W    = 2;
    localparam int RES_SLOT_W  = 6;
    localparam int REF_COUNT_W = 16;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 7'd64;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_ACQUIRE = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_BAD_ID = 2'd2,
        STS_UNREG  = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } rcst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_hold;
    } rcst_sts_t;

endpackage

>>> hdl/rcst_ctrl.sv
// controller state machine of the slot table
module rcst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rcst_pkg::rcst_sts_t sts,
    output rcst_pkg::rcst_cmd_t cmd
);
    import rcst_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall    = (state_reg != ST_IDLE);
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.commit  = (state_reg == ST_RUN) && !sts.out_hold;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!sts.out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/rcst_dpath.sv
// datapath of the slot table: valid bits, count memory, free search, result register
module rcst_dpath
#(
    parameter int SLOTS      = rcst_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = rcst_pkg::COUNT_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rcst_pkg::CFG_W-1:0]       cfg_data,
    input  logic [rcst_pkg::REQ_W-1:0]       req_type,
    input  logic [rcst_pkg::ID_W-1:0]        slot_id,
    input  logic                             auto_release,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rcst_pkg::STATUS_W-1:0]    status,
    output logic [rcst_pkg::RES_SLOT_W-1:0]  result_slot,
    output logic [rcst_pkg::REF_COUNT_W-1:0] ref_count,
    output logic                             freed,
    input  rcst_pkg::rcst_cmd_t              cmd,
    output rcst_pkg::rcst_sts_t              sts
);
    import rcst_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);
    localparam int UW = (NW > CFG_W) ? NW : CFG_W;
    localparam int CW = (UW > ID_W) ? UW : ID_W;
    localparam int SW = (IW > RES_SLOT_W) ? IW : RES_SLOT_W;
    localparam int KW = (COUNT_BITS > REF_COUNT_W) ? COUNT_BITS : REF_COUNT_W;
    localparam int MW = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // configuration
    logic [CFG_W-1:0] slots_in_use_reg;

    // slot state: valid bits in flops, {auto_release, count} in memory
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic [MW-1:0]    slot_mem [SLOTS];
    logic [MW-1:0]    rd_data_reg;

    // captured request
    req_t             req_reg;
    logic             auto_reg;
    logic             id_ok_reg;
    logic             live_reg;
    logic [IW-1:0]    idx_reg;
    logic             free_found_reg;
    logic [IW-1:0]    free_idx_reg;

    // result register
    logic                   out_valid_reg;
    status_t                status_reg;
    logic [RES_SLOT_W-1:0]  result_slot_reg;
    logic [REF_COUNT_W-1:0] ref_count_reg;
    logic                   freed_reg;

    // capture-side logic
    logic [UW-1:0]    usable;
    logic [UW-1:0]    cfg_ext;
    logic [CW-1:0]    id_ext;
    logic [IW-1:0]    idx_in;
    logic             id_ok_in;
    logic [SLOTS-1:0] avail;
    logic [SLOTS-1:0] lowest;
    logic [IW-1:0]    free_idx_in;

    // commit-side logic
    logic [COUNT_BITS-1:0] cnt;
    logic                  cnt_auto;
    logic [COUNT_BITS-1:0] cnt_new;
    status_t               status_c;
    logic [IW-1:0]         slot_c;
    logic [COUNT_BITS-1:0] count_c;
    logic                  freed_c;
    logic                  mem_we;
    logic [IW-1:0]         mem_addr;
    logic [MW-1:0]         mem_wdata;
    logic                  alloc_hit;

    assign cfg_ext  = UW'(slots_in_use_reg);
    assign usable   = (cfg_ext < UW'(SLOTS)) ? cfg_ext : UW'(SLOTS);
    assign id_ext   = CW'(slot_id);
    assign idx_in   = id_ext[IW-1:0];
    assign id_ok_in = (id_ext < CW'(usable));

    // free slots within the usable range, lowest one isolated
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            avail[i] = !valid_reg[i] && (UW'(i) < usable);
        end
    end

    assign lowest = avail & (~avail + SLOTS'(1));

    always_comb
    begin
        free_idx_in = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (lowest[i])
            begin
                free_idx_in = free_idx_in | IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg        <= req_t'(req_type);
            auto_reg       <= auto_release;
            id_ok_reg      <= id_ok_in;
            live_reg       <= id_ok_in && valid_reg[idx_in];
            idx_reg        <= idx_in;
            free_found_reg <= |avail;
            free_idx_reg   <= free_idx_in;
            rd_data_reg    <= slot_mem[idx_in];
        end
        if (mem_we)
        begin
            slot_mem[mem_addr] <= mem_wdata;
        end
    end

    assign cnt       = rd_data_reg[COUNT_BITS-1:0];
    assign cnt_auto  = rd_data_reg[COUNT_BITS];
    assign alloc_hit = (req_reg == REQ_ALLOC) && free_found_reg;

    // read-modify-write of the addressed slot
    always_comb
    begin
        status_c   = STS_OK;
        slot_c     = '0;
        count_c    = '0;
        freed_c    = 1'b0;
        cnt_new    = cnt;
        mem_we     = 1'b0;
        mem_addr   = idx_reg;
        mem_wdata  = rd_data_reg;
        valid_next = valid_reg;
        case (req_reg)
            REQ_ALLOC:
            begin
                if (free_found_reg)
                begin
                    slot_c    = free_idx_reg;
                    count_c   = COUNT_ONE;
                    mem_we    = cmd.commit;
                    mem_addr  = free_idx_reg;
                    mem_wdata = {auto_reg, COUNT_ONE};
                    if (cmd.commit)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                    end
                end
                else
                begin
                    status_c = STS_FULL;
                end
            end
            REQ_ACQUIRE, REQ_RELEASE:
            begin
                if (!id_ok_reg)
                begin
                    status_c = STS_BAD_ID;
                end
                else if (!live_reg)
                begin
                    status_c = STS_UNREG;
                end
                else
                begin
                    if (req_reg == REQ_ACQUIRE)
                    begin
                        cnt_new = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_ONE;
                    end
                    else
                    begin
                        cnt_new = (cnt != '0) ? cnt - COUNT_ONE : cnt;
                    end
                    slot_c    = idx_reg;
                    mem_we    = cmd.commit;
                    if ((req_reg == REQ_RELEASE) && (cnt_new == '0) && cnt_auto)
                    begin
                        // auto-release slot drained: free it
                        freed_c   = 1'b1;
                        mem_wdata = '0;
                        if (cmd.commit)
                        begin
                            valid_next[idx_reg] = 1'b0;
                        end
                    end
                    else
                    begin
                        count_c   = cnt_new;
                        mem_wdata = {cnt_auto, cnt_new};
                    end
                end
            end
            default:
            begin
                status_c = STS_BAD_ID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
            valid_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                slots_in_use_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg      <= status_c;
            result_slot_reg <= RES_SLOT_W'(SW'(slot_c));
            ref_count_reg   <= REF_COUNT_W'(KW'(count_c));
            freed_reg       <= freed_c;
        end
    end

    assign sts.out_hold = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_slot  = result_slot_reg;
    assign ref_count    = ref_count_reg;
    assign freed        = freed_reg;

    `include "refcounted_slot_table_assert.svh"

    `RCST_ASSERT_NEXT(a_commit_shows_word, cmd.commit, out_valid_reg)
    `RCST_ASSERT_NOW(a_word_from_commit, $rose(out_valid_reg), $past(cmd.commit))
    `RCST_ASSERT_NEXT(a_alloc_marks_valid, cmd.commit && alloc_hit, valid_reg[$past(free_idx_reg)])
    `RCST_ASSERT_NEXT(a_freed_clears_valid, cmd.commit && freed_c, !valid_reg[$past(idx_reg)])

endmodule

>>> hdl/refcounted_slot_table.sv
// top level of the reference-counted slot table
// A table of SLOTS slots, each with a valid bit, an auto-release bit and a
// COUNT_BITS reference count. Every request word gives exactly one result
// word. Allocate claims the lowest free slot below slots_in_use with count 1;
// acquire raises a live slot's count (saturating), release lowers it (not
// below zero) and frees an auto-release slot once its count is zero. A request
// is first captured, which reads the slot's count from the count memory and
// finds the lowest free slot over the valid bits, then committed, which writes
// the updated count back and loads the result register; in_stall is high in
// the commit state, which stretches for as long as the word before it still
// waits behind a stalled output. The next request may be taken while the
// previous result is still waiting. slots_in_use resets to 64; the user must
// write it only while the block is idle, which the block does not enforce.
module refcounted_slot_table
#(
    parameter int SLOTS      = rcst_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = rcst_pkg::COUNT_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write,
    input  logic [rcst_pkg::CFG_W-1:0]       cfg_data,
    // request word
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rcst_pkg::REQ_W-1:0]       req_type,
    input  logic [rcst_pkg::ID_W-1:0]        slot_id,
    input  logic                             auto_release,
    // result word
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rcst_pkg::STATUS_W-1:0]    status,
    output logic [rcst_pkg::RES_SLOT_W-1:0]  result_slot,
    output logic [rcst_pkg::REF_COUNT_W-1:0] ref_count,
    output logic                             freed
);
    import rcst_pkg::*;

    rcst_cmd_t cmd;
    rcst_sts_t sts;

    // sequencing: capture then commit, held while the result register is full
    rcst_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot state, free search, count update and result register
    rcst_dpath
    #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .slot_id      (slot_id),
        .auto_release (auto_release),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_slot  (result_slot),
        .ref_count    (ref_count),
        .freed        (freed),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
